/* rtl/work_stealing_chunk_scheduler_top_defines.svh */
// Assertion macros shared by the work-stealing chunk scheduler RTL.
`ifndef WORK_STEALING_CHUNK_SCHEDULER_TOP_DEFINES_SVH
`define WORK_STEALING_CHUNK_SCHEDULER_TOP_DEFINES_SVH

// Property that must hold at every clock edge outside reset.
`define WSCS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// Condition in one cycle that forces a consequence in the next cycle.
`define WSCS_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error(msg);

`endif

/* rtl/wscs_pkg.sv */
// Shared constants, types and codes of the work-stealing chunk scheduler.
package wscs_pkg;

  localparam int unsigned MAX_WORKERS     = 8;
  localparam int unsigned QUEUE_DEPTH     = 64;
  localparam int unsigned INDEX_BITS      = 24;
  localparam int unsigned DEFAULT_WORKERS = 4;
  localparam int unsigned RESET_CHUNK     = 64;

  localparam int unsigned WID_W       = $clog2(MAX_WORKERS);
  localparam int unsigned WC_W        = 4;
  localparam int unsigned SLOT_W      = $clog2(QUEUE_DEPTH);
  localparam int unsigned CNT_W       = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned STORE_DEPTH = MAX_WORKERS * QUEUE_DEPTH;
  localparam int unsigned K_W         = $clog2(STORE_DEPTH + 1);
  localparam int unsigned ADDR_W      = WID_W + SLOT_W;
  localparam int unsigned ENTRY_W     = 2 * INDEX_BITS;
  localparam int unsigned QW          = INDEX_BITS + 1;
  localparam int unsigned STEP_W      = $clog2(QW);

  localparam int unsigned OP_W       = 2;
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 24;

  // Operation codes of an input word.
  localparam logic [OP_W-1:0] OP_SUBMIT  = OP_W'(0);
  localparam logic [OP_W-1:0] OP_REQUEST = OP_W'(1);
  localparam logic [OP_W-1:0] OP_CLEAR   = OP_W'(2);

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_WORKERS = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_CHUNK   = CFG_IDX_W'(1);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_PUSH,
    ST_REQ,
    ST_SCAN,
    ST_READ,
    ST_RESP
  } state_e;

  // Status of the chunk-count divider.
  typedef struct packed {
    logic             done;
    logic [QW-1:0]    quot;
    logic [WID_W-1:0] nmod;
  } div_status_t;

endpackage

/* rtl/wscs_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module wscs_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // One write and one registered read per cycle.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/wscs_div.sv */
// Bit-serial restoring divider that counts chunks and folds the count modulo the workers.
`include "work_stealing_chunk_scheduler_top_defines.svh"

module wscs_div (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [wscs_pkg::QW-1:0]       num_i,
  input  logic [wscs_pkg::INDEX_BITS-1:0] den_i,
  input  logic [wscs_pkg::WC_W-1:0]     wc_i,
  output wscs_pkg::div_status_t         status_o
);
  import wscs_pkg::*;

  logic              busy_q, busy_d;
  logic              done_q, done_d;
  logic [STEP_W-1:0] step_q, step_d;
  logic [QW-1:0]     num_q, num_d;
  logic [QW-1:0]     rem_q, rem_d;
  logic [QW-1:0]     quot_q, quot_d;
  logic [INDEX_BITS-1:0] den_q, den_d;
  logic [WID_W-1:0]  nmod_q, nmod_d;

  logic [QW-1:0]     rem_sh;
  logic              qbit;
  logic [WC_W-1:0]   mod_sh;

  // One quotient bit a step, most significant first; the remainder modulo the
  // worker count follows the quotient bits as they appear.
  always_comb begin
    rem_sh = {rem_q[QW-2:0], num_q[QW-1]};
    qbit   = (rem_sh >= {1'b0, den_q});
    mod_sh = {nmod_q, qbit};

    busy_d = busy_q;
    done_d = done_q;
    step_d = step_q;
    num_d  = num_q;
    rem_d  = rem_q;
    quot_d = quot_q;
    den_d  = den_q;
    nmod_d = nmod_q;

    if (start_i) begin
      busy_d = 1'b1;
      done_d = 1'b0;
      step_d = '0;
      num_d  = num_i;
      rem_d  = '0;
      quot_d = '0;
      den_d  = den_i;
      nmod_d = '0;
    end else if (busy_q) begin
      num_d  = {num_q[QW-2:0], 1'b0};
      rem_d  = qbit ? (rem_sh - {1'b0, den_q}) : rem_sh;
      quot_d = {quot_q[QW-2:0], qbit};
      nmod_d = (mod_sh >= wc_i) ? WID_W'(mod_sh - wc_i) : WID_W'(mod_sh);
      step_d = step_q + STEP_W'(1);
      if (step_q == STEP_W'(QW - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  // Control state is reset; the data path is not.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      step_q <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q  <= num_d;
    rem_q  <= rem_d;
    quot_q <= quot_d;
    den_q  <= den_d;
    nmod_q <= nmod_d;
  end

  assign status_o = '{done: done_q, quot: quot_q, nmod: nmod_q};

  // The folded remainder always stays below the worker count.
  `WSCS_ASSERT(a_nmod_bound, busy_q |-> ({1'b0, nmod_q} < wc_i), "divider remainder out of range")
  // A running division never reports done.
  `WSCS_ASSERT(a_busy_not_done, busy_q |-> !done_q, "divider busy and done together")
  // A start always sets the divider running.
  `WSCS_ASSERT_NEXT(a_start_busy, start_i, busy_q, "divider did not start")

endmodule

/* rtl/work_stealing_chunk_scheduler_top.sv */
// Top level of the work-stealing chunk scheduler: sequencer, queue state and result register.
//
// Usage. Input words arrive on in_valid_i / in_stall_o with op_i, range_start_i,
// range_end_i and worker_id_i. A submit splits the range into chunks of the
// configured size and deals them round-robin over the worker queues; a request
// pops the newest chunk of the worker's own queue or steals the oldest chunk of
// the first other non-empty queue; a clear empties every queue. Each input word
// gives exactly one result word on out_valid_o / out_stall_i.
// Timing. One word is worked on at a time. A submit runs the bit-serial
// chunk-count divider, then pushes its chunks into the chunk RAM (at most 512),
// then posts the result. A request pops its own queue when that holds a chunk,
// else scans the queues, the scan visiting one queue a cycle. A clear goes
// straight to posting its result. The result sits in an output register, so the
// next word is taken while it waits; a stalled result holds the sequencer only
// when a second result is ready. Reset empties all queues, sets worker_count to
// 4 and chunk_size to 64. The chunk RAM needs no clearing: entries are read
// only after they are written.
`include "work_stealing_chunk_scheduler_top_defines.svh"

module work_stealing_chunk_scheduler_top (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [wscs_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [wscs_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic [wscs_pkg::OP_W-1:0]         op_i,
  input  logic [wscs_pkg::INDEX_BITS-1:0]   range_start_i,
  input  logic [wscs_pkg::INDEX_BITS-1:0]   range_end_i,
  input  logic [wscs_pkg::WID_W-1:0]        worker_id_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic                              chunk_valid_o,
  output logic [wscs_pkg::INDEX_BITS-1:0]   chunk_start_o,
  output logic [wscs_pkg::INDEX_BITS-1:0]   chunk_end_o,
  output logic [wscs_pkg::WID_W-1:0]        source_queue_o,
  output logic                              was_stolen_o,
  output logic [wscs_pkg::K_W-1:0]          chunks_added_o,
  output logic                              overflow_o
);
  import wscs_pkg::*;

  // Configuration registers.
  logic [WC_W-1:0]       cfg_workers_q;
  logic [INDEX_BITS-1:0] cfg_chunk_q;

  // Sequencer and queue state.
  state_e                state_q, state_d;
  logic [SLOT_W-1:0]     head_q [MAX_WORKERS];
  logic [SLOT_W-1:0]     head_d [MAX_WORKERS];
  logic [CNT_W-1:0]      cnt_q [MAX_WORKERS];
  logic [CNT_W-1:0]      cnt_d [MAX_WORKERS];
  logic [WID_W-1:0]      next_target_q, next_target_d;

  // Working registers of the word in flight.
  logic [INDEX_BITS-1:0] s_q, s_d;
  logic [INDEX_BITS-1:0] re_q, re_d;
  logic [WID_W-1:0]      wid_q, wid_d;
  logic [WID_W-1:0]      tgt_q, tgt_d;
  logic [WID_W-1:0]      cur_q, cur_d;
  logic [WC_W-1:0]       scan_q, scan_d;
  logic [QW-1:0]         n_q, n_d;
  logic [K_W-1:0]        k_q, k_d;

  // Result being built.
  logic                  res_valid_q, res_valid_d;
  logic [INDEX_BITS-1:0] res_start_q, res_start_d;
  logic [INDEX_BITS-1:0] res_end_q, res_end_d;
  logic [WID_W-1:0]      res_src_q, res_src_d;
  logic                  res_stolen_q, res_stolen_d;
  logic [K_W-1:0]        res_added_q, res_added_d;
  logic                  res_ovf_q, res_ovf_d;

  // Output register.
  logic                  out_valid_q, out_valid_d;
  logic                  out_chunk_valid_q, out_chunk_valid_d;
  logic [INDEX_BITS-1:0] out_start_q, out_start_d;
  logic [INDEX_BITS-1:0] out_end_q, out_end_d;
  logic [WID_W-1:0]      out_src_q, out_src_d;
  logic                  out_stolen_q, out_stolen_d;
  logic [K_W-1:0]        out_added_q, out_added_d;
  logic                  out_ovf_q, out_ovf_d;

  // Chunk RAM and divider connections.
  logic                  ram_we, ram_re;
  logic [ADDR_W-1:0]     ram_waddr, ram_raddr;
  logic [ENTRY_W-1:0]    ram_wdata, ram_rdata;
  logic                  div_start;
  logic [QW-1:0]         div_num;
  div_status_t           div_st;

  // Derived values.
  logic                  accept;
  logic [WC_W-1:0]       wc_eff;
  logic [INDEX_BITS-1:0] cs_eff;
  logic [K_W-1:0]        limit;
  logic [INDEX_BITS-1:0] range_len;
  logic [WID_W-1:0]      sel;
  logic [SLOT_W-1:0]     head_sel;
  logic [CNT_W-1:0]      cnt_sel;
  logic [INDEX_BITS:0]   e_full;
  logic [INDEX_BITS-1:0] e_clip;
  logic [K_W-1:0]        k_inc;
  logic                  push_last;
  logic [WC_W-1:0]       cur_inc;
  logic                  own_hit;
  logic                  scan_end;
  logic                  scan_hit;
  logic                  div_exit;
  logic [WC_W-1:0]       tgt_sum;
  logic                  out_free;

  // Configuration writes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_workers_q <= WC_W'(DEFAULT_WORKERS);
      cfg_chunk_q   <= INDEX_BITS'(RESET_CHUNK);
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_WORKERS: cfg_workers_q <= cfg_data_i[WC_W-1:0];
        CFG_CHUNK:   cfg_chunk_q   <= cfg_data_i[INDEX_BITS-1:0];
        default:     cfg_chunk_q   <= cfg_chunk_q;
      endcase
    end
  end

  // Effective worker count, chunk size and the per-submit chunk limit.
  always_comb begin
    if (cfg_workers_q == '0) begin
      wc_eff = WC_W'(DEFAULT_WORKERS);
    end else if (cfg_workers_q > WC_W'(MAX_WORKERS)) begin
      wc_eff = WC_W'(MAX_WORKERS);
    end else begin
      wc_eff = cfg_workers_q;
    end
    cs_eff = (cfg_chunk_q == '0) ? INDEX_BITS'(1) : cfg_chunk_q;
    limit  = K_W'(wc_eff) * K_W'(QUEUE_DEPTH);
  end

  assign in_stall_o = (state_q != ST_IDLE);
  assign accept     = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;

  // Chunk count of a submit is ceil(len / chunk_size), worked out by the divider.
  assign range_len = (range_start_i < range_end_i) ? (range_end_i - range_start_i) : '0;
  assign div_num   = QW'(range_len) + QW'(cs_eff) - QW'(1);
  assign div_start = accept && (op_i == OP_SUBMIT);

  wscs_div u_div (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (div_start),
    .num_i    (div_num),
    .den_i    (cs_eff),
    .wc_i     (wc_eff),
    .status_o (div_st)
  );

  // The queue whose head and count are looked at this cycle.
  always_comb begin
    case (state_q)
      ST_REQ:  sel = wid_q;
      ST_SCAN: sel = scan_q[WID_W-1:0];
      default: sel = cur_q;
    endcase
    head_sel = head_q[sel];
    cnt_sel  = cnt_q[sel];
  end

  // Chunk bounds, loop bookkeeping and queue search conditions.
  always_comb begin
    e_full    = {1'b0, s_q} + {1'b0, cs_eff};
    e_clip    = (e_full > {1'b0, re_q}) ? re_q : e_full[INDEX_BITS-1:0];
    k_inc     = k_q + K_W'(1);
    push_last = (QW'(k_inc) >= n_q) || (k_inc >= limit);
    cur_inc   = {1'b0, cur_q} + WC_W'(1);
    own_hit   = ({1'b0, wid_q} < wc_eff) && (cnt_sel != '0);
    scan_end  = (scan_q >= wc_eff);
    scan_hit  = (scan_q[WID_W-1:0] != wid_q) && (cnt_sel != '0);
    div_exit  = div_st.done && ({1'b0, tgt_q} < wc_eff);
    tgt_sum   = {1'b0, tgt_q} + {1'b0, div_st.nmod};
    if (tgt_sum >= wc_eff) begin
      tgt_sum = tgt_sum - wc_eff;
    end
  end

  // Next state of the sequencer.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          case (op_i)
            OP_SUBMIT:  state_d = ST_DIV;
            OP_REQUEST: state_d = ST_REQ;
            default:    state_d = ST_RESP;
          endcase
        end
      end
      ST_DIV: begin
        if (div_exit) begin
          state_d = (div_st.quot == '0) ? ST_RESP : ST_PUSH;
        end
      end
      ST_PUSH: begin
        if (push_last) begin
          state_d = ST_RESP;
        end
      end
      ST_REQ:  state_d = own_hit ? ST_READ : ST_SCAN;
      ST_SCAN: begin
        if (scan_end) begin
          state_d = ST_RESP;
        end else if (scan_hit) begin
          state_d = ST_READ;
        end
      end
      ST_READ: state_d = ST_RESP;
      ST_RESP: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Data path and memory controls of each sequencer state.
  always_comb begin
    head_d        = head_q;
    cnt_d         = cnt_q;
    next_target_d = next_target_q;
    s_d           = s_q;
    re_d          = re_q;
    wid_d         = wid_q;
    tgt_d         = tgt_q;
    cur_d         = cur_q;
    scan_d        = scan_q;
    n_d           = n_q;
    k_d           = k_q;
    res_valid_d   = res_valid_q;
    res_start_d   = res_start_q;
    res_end_d     = res_end_q;
    res_src_d     = res_src_q;
    res_stolen_d  = res_stolen_q;
    res_added_d   = res_added_q;
    res_ovf_d     = res_ovf_q;
    ram_we        = 1'b0;
    ram_waddr     = {cur_q, head_sel + cnt_sel[SLOT_W-1:0]};
    ram_wdata     = {e_clip, s_q};
    ram_re        = 1'b0;
    ram_raddr     = {sel, head_sel};

    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          s_d          = range_start_i;
          re_d         = range_end_i;
          wid_d        = worker_id_i;
          tgt_d        = next_target_q;
          scan_d       = '0;
          k_d          = '0;
          res_valid_d  = 1'b0;
          res_start_d  = '0;
          res_end_d    = '0;
          res_src_d    = '0;
          res_stolen_d = 1'b0;
          res_added_d  = '0;
          res_ovf_d    = 1'b0;
          if (op_i == OP_CLEAR) begin
            for (int i = 0; i < MAX_WORKERS; i++) begin
              head_d[i] = '0;
              cnt_d[i]  = '0;
            end
            next_target_d = '0;
          end
        end
      end
      ST_DIV: begin
        // Fold a stale target into range while the divider runs.
        if ({1'b0, tgt_q} >= wc_eff) begin
          tgt_d = tgt_q - wc_eff[WID_W-1:0];
        end
        if (div_exit) begin
          n_d           = div_st.quot;
          cur_d         = tgt_q;
          next_target_d = tgt_sum[WID_W-1:0];
          res_ovf_d     = (div_st.quot > QW'(limit));
        end
      end
      ST_PUSH: begin
        // One chunk a cycle onto the back of the current queue.
        if (cnt_sel < CNT_W'(QUEUE_DEPTH)) begin
          ram_we      = 1'b1;
          cnt_d[cur_q] = cnt_sel + CNT_W'(1);
          res_added_d = res_added_q + K_W'(1);
        end else begin
          res_ovf_d = 1'b1;
        end
        s_d   = s_q + cs_eff;
        k_d   = k_inc;
        cur_d = (cur_inc == wc_eff) ? '0 : cur_inc[WID_W-1:0];
      end
      ST_REQ: begin
        // Own queue: take the newest chunk.
        if (own_hit) begin
          ram_re        = 1'b1;
          ram_raddr     = {wid_q, head_sel + cnt_sel[SLOT_W-1:0] - SLOT_W'(1)};
          cnt_d[wid_q]  = cnt_sel - CNT_W'(1);
          res_src_d     = wid_q;
          res_stolen_d  = 1'b0;
        end
      end
      ST_SCAN: begin
        // Steal the oldest chunk of the first other queue that holds one.
        if (!scan_end) begin
          if (scan_hit) begin
            ram_re       = 1'b1;
            ram_raddr    = {scan_q[WID_W-1:0], head_sel};
            head_d[scan_q[WID_W-1:0]] = head_sel + SLOT_W'(1);
            cnt_d[scan_q[WID_W-1:0]]  = cnt_sel - CNT_W'(1);
            res_src_d    = scan_q[WID_W-1:0];
            res_stolen_d = 1'b1;
          end else begin
            scan_d = scan_q + WC_W'(1);
          end
        end
      end
      ST_READ: begin
        res_valid_d = 1'b1;
        res_start_d = ram_rdata[INDEX_BITS-1:0];
        res_end_d   = ram_rdata[ENTRY_W-1:INDEX_BITS];
      end
      default: begin
        res_valid_d = res_valid_q;
      end
    endcase
  end

  // Output register: loaded when a result is finished and the slot is free.
  always_comb begin
    out_valid_d       = out_valid_q && out_stall_i;
    out_chunk_valid_d = out_chunk_valid_q;
    out_start_d       = out_start_q;
    out_end_d         = out_end_q;
    out_src_d         = out_src_q;
    out_stolen_d      = out_stolen_q;
    out_added_d       = out_added_q;
    out_ovf_d         = out_ovf_q;
    if ((state_q == ST_RESP) && out_free) begin
      out_valid_d       = 1'b1;
      out_chunk_valid_d = res_valid_q;
      out_start_d       = res_start_q;
      out_end_d         = res_end_q;
      out_src_d         = res_valid_q ? res_src_q : '0;
      out_stolen_d      = res_valid_q && res_stolen_q;
      out_added_d       = res_added_q;
      out_ovf_d         = res_ovf_q;
    end
  end

  // Control state with reset.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      next_target_q <= '0;
      out_valid_q   <= 1'b0;
      for (int i = 0; i < MAX_WORKERS; i++) begin
        head_q[i] <= '0;
        cnt_q[i]  <= '0;
      end
    end else begin
      state_q       <= state_d;
      next_target_q <= next_target_d;
      out_valid_q   <= out_valid_d;
      head_q        <= head_d;
      cnt_q         <= cnt_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    s_q               <= s_d;
    re_q              <= re_d;
    wid_q             <= wid_d;
    tgt_q             <= tgt_d;
    cur_q             <= cur_d;
    scan_q            <= scan_d;
    n_q               <= n_d;
    k_q               <= k_d;
    res_valid_q       <= res_valid_d;
    res_start_q       <= res_start_d;
    res_end_q         <= res_end_d;
    res_src_q         <= res_src_d;
    res_stolen_q      <= res_stolen_d;
    res_added_q       <= res_added_d;
    res_ovf_q         <= res_ovf_d;
    out_chunk_valid_q <= out_chunk_valid_d;
    out_start_q       <= out_start_d;
    out_end_q         <= out_end_d;
    out_src_q         <= out_src_d;
    out_stolen_q      <= out_stolen_d;
    out_added_q       <= out_added_d;
    out_ovf_q         <= out_ovf_d;
  end

  // Chunk store: one row per queue slot, {end, start}.
  wscs_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (STORE_DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign out_valid_o    = out_valid_q;
  assign chunk_valid_o  = out_chunk_valid_q;
  assign chunk_start_o  = out_start_q;
  assign chunk_end_o    = out_end_q;
  assign source_queue_o = out_src_q;
  assign was_stolen_o   = out_stolen_q;
  assign chunks_added_o = out_added_q;
  assign overflow_o     = out_ovf_q;

  // An accepted submit always starts the divider pass.
  `WSCS_ASSERT_NEXT(a_submit_divides, accept && (op_i == OP_SUBMIT), state_q == ST_DIV, "submit did not start the divider")
  // While chunks are dealt out, the stored target already lies inside the worker count.
  `WSCS_ASSERT(a_target_bound, (state_q == ST_PUSH) |-> ({1'b0, next_target_q} < wc_eff), "next target outside worker count")
  // Reading a chunk always follows a pop that issued the RAM read.
  `WSCS_ASSERT(a_read_after_pop, (state_q == ST_READ) |-> $past(ram_re), "chunk read without a pop")

endmodule
